[hdl/sct_pkg.sv]
// Package for the sleep countdown table: result field widths, result kinds,
// and the command and status structs between controller and datapath.
// No dependencies.
package sct_pkg;

    localparam int KIND_W  = 2;
    localparam int ID_W    = 8;
    localparam int SLOT_W  = 6;
    localparam int WAIT_W  = 7;
    localparam int DELAY_W = 16;

    typedef logic [KIND_W-1:0] kind_t;

    localparam kind_t KIND_SLEEP = 2'd0;
    localparam kind_t KIND_FULL  = 2'd1;
    localparam kind_t KIND_WOKEN = 2'd2;
    localparam kind_t KIND_IDLE  = 2'd3;

    // controller -> datapath
    typedef struct packed {
        logic load;     // capture request, restart slot walk
        logic idx_inc;  // advance slot index
        logic rd_en;    // read owner and remaining count of current slot
        logic claim;    // fill current slot, send sleep result
        logic full;     // send table-full result
        logic wake;     // free current slot, hold its wake result
        logic dec;      // write back remaining count less one
        logic finish;   // send final result of a tick
    } ctl_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic new_sleep;  // offered request is a sleep request
        logic busy_cur;   // current slot occupied
        logic idx_last;   // current slot is the last one
        logic expired;    // read count is one or less
        logic pend_valid; // a wake result is held back
        logic out_free;   // output register can take a result
    } ctl_sts_t;

endpackage

[hdl/sct_in_if.sv]
// Request channel of the sleep countdown table: valid/ready and payload.
// Depends on sct_pkg.
interface sct_in_if;
    logic                        valid;
    logic                        ready;
    logic                        cmd;
    logic [sct_pkg::ID_W-1:0]    thread_id;
    logic [sct_pkg::DELAY_W-1:0] delay;

    modport source (output valid, cmd, thread_id, delay, input ready);
    modport sink   (input valid, cmd, thread_id, delay, output ready);
endinterface

[hdl/sct_out_if.sv]
// Result channel of the sleep countdown table: valid/ready and payload.
// Depends on sct_pkg.
interface sct_out_if;
    logic                       valid;
    logic                       ready;
    logic [sct_pkg::KIND_W-1:0] kind;
    logic [sct_pkg::ID_W-1:0]   woken_thread;
    logic [sct_pkg::SLOT_W-1:0] slot_index;
    logic [sct_pkg::WAIT_W-1:0] waiting_count;
    logic                       last;

    modport source (output valid, kind, woken_thread, slot_index, waiting_count, last,
                    input ready);
    modport sink   (input valid, kind, woken_thread, slot_index, waiting_count, last,
                    output ready);
endinterface

[hdl/sct_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module sct_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                 clk,
    input  logic                                 we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                     wdata,
    input  logic                                 re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                     rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end
endmodule

[hdl/sct_ctrl.sv]
// Controller of the sleep countdown table: walks the slots one at a time.
// Depends on sct_pkg.
module sct_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_ready,
    input  sct_pkg::ctl_sts_t sts,
    output sct_pkg::ctl_cmd_t cmd
);
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SLEEP = 3'd1;
    localparam logic [2:0] S_SCAN  = 3'd2;
    localparam logic [2:0] S_EVAL  = 3'd3;
    localparam logic [2:0] S_DONE  = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        cmd        = '0;
        req_ready  = 1'b0;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = sts.new_sleep ? S_SLEEP : S_SCAN;
                end
            end
            S_SLEEP:
            begin
                // look for the lowest free slot
                if (!sts.busy_cur)
                begin
                    if (sts.out_free)
                    begin
                        cmd.claim  = 1'b1;
                        state_next = S_IDLE;
                    end
                end
                else if (sts.idx_last)
                begin
                    if (sts.out_free)
                    begin
                        cmd.full   = 1'b1;
                        state_next = S_IDLE;
                    end
                end
                else
                begin
                    cmd.idx_inc = 1'b1;
                end
            end
            S_SCAN:
            begin
                if (sts.busy_cur)
                begin
                    cmd.rd_en  = 1'b1;
                    state_next = S_EVAL;
                end
                else if (sts.idx_last)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.idx_inc = 1'b1;
                end
            end
            S_EVAL:
            begin
                // hold while a held wake result cannot move to the output
                if (!(sts.expired && sts.pend_valid && !sts.out_free))
                begin
                    cmd.wake = sts.expired;
                    cmd.dec  = !sts.expired;
                    if (sts.idx_last)
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        cmd.idx_inc = 1'b1;
                        state_next  = S_SCAN;
                    end
                end
            end
            S_DONE:
            begin
                if (sts.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end
endmodule

[hdl/sct_dpath.sv]
// Datapath of the sleep countdown table: busy bits, slot RAM, waiting count,
// held wake result and output register. Depends on sct_pkg and sct_ram.
module sct_dpath #(
    parameter int SLOTS   = 10,
    parameter int ID_BITS = 8
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  sct_pkg::ctl_cmd_t           cmd,
    output sct_pkg::ctl_sts_t           sts,
    input  logic                        req_cmd,
    input  logic [sct_pkg::ID_W-1:0]    req_thread_id,
    input  logic [sct_pkg::DELAY_W-1:0] req_delay,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [sct_pkg::KIND_W-1:0]  out_kind,
    output logic [sct_pkg::ID_W-1:0]    out_woken_thread,
    output logic [sct_pkg::SLOT_W-1:0]  out_slot_index,
    output logic [sct_pkg::WAIT_W-1:0]  out_waiting_count,
    output logic                        out_last
);
    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W = $clog2(SLOTS + 1);
    localparam int OWN_W = (ID_BITS < sct_pkg::ID_W) ? ID_BITS : sct_pkg::ID_W;
    localparam int ENT_W = OWN_W + sct_pkg::DELAY_W;

    logic [SLOTS-1:0]            busy_reg;
    logic [IDX_W-1:0]            idx_reg;
    logic [CNT_W-1:0]            count_reg;
    logic [OWN_W-1:0]            id_reg;
    logic [sct_pkg::DELAY_W-1:0] delay_reg;
    logic                        pend_valid_reg;
    logic [OWN_W-1:0]            pend_owner_reg;
    logic [IDX_W-1:0]            pend_idx_reg;
    logic [CNT_W-1:0]            pend_count_reg;
    logic                        out_valid_reg;
    sct_pkg::kind_t              out_kind_reg;
    logic [OWN_W-1:0]            out_id_reg;
    logic [IDX_W-1:0]            out_idx_reg;
    logic [CNT_W-1:0]            out_count_reg;
    logic                        out_last_reg;

    logic                        ram_we;
    logic [ENT_W-1:0]            ram_wdata;
    logic [ENT_W-1:0]            ram_rdata;
    logic [OWN_W-1:0]            rd_owner;
    logic [sct_pkg::DELAY_W-1:0] rd_rem;
    logic                        out_free;
    logic                        push;

    assign rd_owner  = ram_rdata[ENT_W-1 -: OWN_W];
    assign rd_rem    = ram_rdata[sct_pkg::DELAY_W-1:0];
    assign ram_we    = cmd.claim | cmd.dec;
    assign ram_wdata = cmd.claim ? {id_reg, delay_reg} : {rd_owner, rd_rem - 16'd1};

    sct_ram #(
        .WIDTH (ENT_W),
        .DEPTH (SLOTS)
    ) u_slot_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (idx_reg),
        .wdata (ram_wdata),
        .re    (cmd.rd_en),
        .raddr (idx_reg),
        .rdata (ram_rdata)
    );

    assign out_free = !out_valid_reg || out_ready;
    assign push     = cmd.claim | cmd.full | (cmd.wake & pend_valid_reg) | cmd.finish;

    always_comb
    begin
        sts.new_sleep  = req_cmd;
        sts.busy_cur   = busy_reg[idx_reg];
        sts.idx_last   = (idx_reg == IDX_W'(SLOTS - 1));
        sts.expired    = (rd_rem[sct_pkg::DELAY_W-1:1] == '0);
        sts.pend_valid = pend_valid_reg;
        sts.out_free   = out_free;
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg       <= '0;
            count_reg      <= '0;
            idx_reg        <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.load)
            begin
                idx_reg <= '0;
            end
            else if (cmd.idx_inc)
            begin
                idx_reg <= idx_reg + 1'b1;
            end

            if (cmd.claim)
            begin
                busy_reg[idx_reg] <= 1'b1;
                count_reg         <= count_reg + 1'b1;
            end
            else if (cmd.wake)
            begin
                busy_reg[idx_reg] <= 1'b0;
                count_reg         <= count_reg - 1'b1;
            end

            if (cmd.load || cmd.finish)
            begin
                pend_valid_reg <= 1'b0;
            end
            else if (cmd.wake)
            begin
                pend_valid_reg <= 1'b1;
            end

            if (push)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            id_reg    <= req_thread_id[OWN_W-1:0];
            delay_reg <= req_delay;
        end

        if (cmd.wake)
        begin
            pend_owner_reg <= rd_owner;
            pend_idx_reg   <= idx_reg;
            pend_count_reg <= count_reg - 1'b1;
        end

        priority if (cmd.claim)
        begin
            out_kind_reg  <= sct_pkg::KIND_SLEEP;
            out_id_reg    <= id_reg;
            out_idx_reg   <= idx_reg;
            out_count_reg <= count_reg + 1'b1;
            out_last_reg  <= 1'b1;
        end
        else if (cmd.full)
        begin
            out_kind_reg  <= sct_pkg::KIND_FULL;
            out_id_reg    <= id_reg;
            out_idx_reg   <= '0;
            out_count_reg <= count_reg;
            out_last_reg  <= 1'b1;
        end
        else if ((cmd.wake || cmd.finish) && pend_valid_reg)
        begin
            // release the held wake; it is the final one only at the end of the walk
            out_kind_reg  <= sct_pkg::KIND_WOKEN;
            out_id_reg    <= pend_owner_reg;
            out_idx_reg   <= pend_idx_reg;
            out_count_reg <= pend_count_reg;
            out_last_reg  <= cmd.finish;
        end
        else if (cmd.finish)
        begin
            out_kind_reg  <= sct_pkg::KIND_IDLE;
            out_id_reg    <= '0;
            out_idx_reg   <= '0;
            out_count_reg <= count_reg;
            out_last_reg  <= 1'b1;
        end
        else
        begin
            // hold the current result
            out_kind_reg <= out_kind_reg;
        end
    end

    assign out_valid         = out_valid_reg;
    assign out_kind          = out_kind_reg;
    assign out_woken_thread  = sct_pkg::ID_W'(out_id_reg);
    assign out_slot_index    = sct_pkg::SLOT_W'(out_idx_reg);
    assign out_waiting_count = sct_pkg::WAIT_W'(out_count_reg);
    assign out_last          = out_last_reg;

    a_count_matches_busy: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg == CNT_W'($countones(busy_reg)))
        else $error("waiting count differs from occupied slots");

    a_push_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> out_free)
        else $error("result pushed over an untaken result");

    a_claim_free_slot: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.claim |-> !busy_reg[idx_reg])
        else $error("sleep request filled an occupied slot");

    a_wake_busy_slot: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.wake || cmd.dec) |-> busy_reg[idx_reg])
        else $error("slot updated without being occupied");
endmodule

[hdl/sleep_countdown_table.sv]
// Sleep request: the slots are walked from the lowest up to the first free one, which is filled;
//   if none is free a table-full result is sent. Either result waits for a free output register.
// Tick: free slots are passed over; an occupied one gets a registered RAM read, then a decision
//   (wake, or write back the count less one). The walk ends with the final result of the tick.
// One item at a time; the output register lets the next request in while a result waits.
// Reset (rst_n, asynchronous, active low) frees every slot and zeroes the count.
module sleep_countdown_table #(
    parameter int SLOTS   = 10,
    parameter int ID_BITS = 8
) (
    input  logic      clk,
    input  logic      rst_n,
    sct_in_if.sink    req,
    sct_out_if.source rsp
);
    // The controller sequences the slot walk; the datapath holds the busy
    // bits, the slot RAM (owner id and remaining ticks), the waiting count,
    // one held-back wake result, and the output register.
    //
    // A tick cannot tell whether a wake is its last until the walk ends, so
    // each wake is held and released with last low when the next one turns
    // up, or with last high at the end of the walk. A tick that wakes
    // nothing sends one idle-tick result instead.

    sct_pkg::ctl_cmd_t cmd;
    sct_pkg::ctl_sts_t sts;

    sct_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    sct_dpath #(
        .SLOTS   (SLOTS),
        .ID_BITS (ID_BITS)
    ) u_dpath (
        .clk               (clk),
        .rst_n             (rst_n),
        .cmd               (cmd),
        .sts               (sts),
        .req_cmd           (req.cmd),
        .req_thread_id     (req.thread_id),
        .req_delay         (req.delay),
        .out_valid         (rsp.valid),
        .out_ready         (rsp.ready),
        .out_kind          (rsp.kind),
        .out_woken_thread  (rsp.woken_thread),
        .out_slot_index    (rsp.slot_index),
        .out_waiting_count (rsp.waiting_count),
        .out_last          (rsp.last)
    );
endmodule

[tb/tb.sv]
`timescale 1ns / 100ps
// Self-checking bench for sleep_countdown_table: directed table, then random requests and ticks.
// Depends on sct_pkg, sct_in_if, sct_out_if and the sleep_countdown_table RTL.
module tb;

    localparam int NUM_SLOTS    = 10;
    localparam int RANDOM_ITEMS = 400;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 4 * NUM_SLOTS + 10;
    localparam int TIMEOUT_NS   = 10_000_000;

    localparam logic CMD_TICK  = 1'b0;
    localparam logic CMD_SLEEP = 1'b1;

    // One result as the block reports it on the result channel.
    typedef struct packed {
        sct_pkg::kind_t              kind;
        logic [sct_pkg::ID_W-1:0]    thread;
        logic [sct_pkg::SLOT_W-1:0]  slot;
        logic [sct_pkg::WAIT_W-1:0]  waiting;
        logic                        last;
    } wake_result_t;

    // One row of the directed table; want is used only where typed is set.
    typedef struct {
        logic                        cmd;
        logic [sct_pkg::ID_W-1:0]    id;
        logic [sct_pkg::DELAY_W-1:0] delay;
        bit                          typed;
        wake_result_t                want;
    } stim_row_t;

    logic clk;
    logic rst_n;

    sct_in_if  req_ch();
    sct_out_if rsp_ch();

    sleep_countdown_table #(
        .SLOTS   (NUM_SLOTS),
        .ID_BITS (sct_pkg::ID_W)
    ) u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    // Our own copy of the sleep table, advanced once per accepted request.
    logic                        slot_taken  [NUM_SLOTS];
    logic [sct_pkg::ID_W-1:0]    slot_thread [NUM_SLOTS];
    logic [sct_pkg::DELAY_W-1:0] slot_ticks  [NUM_SLOTS];
    logic [sct_pkg::WAIT_W-1:0]  sleepers;

    wake_result_t step_results[$];   // results of the request just accepted
    wake_result_t due_results[$];    // results still awaited from the block
    stim_row_t    directed_rows[$];
    int           faults;

    function automatic wake_result_t make_result(sct_pkg::kind_t kind,
                                                 logic [sct_pkg::ID_W-1:0] thread,
                                                 logic [sct_pkg::SLOT_W-1:0] slot,
                                                 logic [sct_pkg::WAIT_W-1:0] waiting,
                                                 logic last);
        wake_result_t r;
        r.kind    = kind;
        r.thread  = thread;
        r.slot    = slot;
        r.waiting = waiting;
        r.last    = last;
        return r;
    endfunction

    // Apply one request to the table copy and collect the results it causes
    // in step_results.
    function automatic void advance_table(logic cmd, logic [sct_pkg::ID_W-1:0] id,
                                          logic [sct_pkg::DELAY_W-1:0] delay);
        bit placed;
        step_results = {};
        if (cmd == CMD_SLEEP)
        begin
            placed = 1'b0;
            for (int s = 0; s < NUM_SLOTS; s++)
            begin
                if (!placed && !slot_taken[s])
                begin
                    slot_taken[s]  = 1'b1;
                    slot_thread[s] = id;
                    slot_ticks[s]  = delay;
                    sleepers       = sleepers + 1'b1;
                    step_results.push_back(make_result(sct_pkg::KIND_SLEEP, id,
                                                       sct_pkg::SLOT_W'(s), sleepers, 1'b1));
                    placed = 1'b1;
                end
            end
            // no free slot: nothing changes, the requester is turned away
            if (!placed)
                step_results.push_back(make_result(sct_pkg::KIND_FULL, id, '0, sleepers,
                                                   1'b1));
        end
        else
        begin
            for (int s = 0; s < NUM_SLOTS; s++)
            begin
                if (slot_taken[s])
                begin
                    // one tick left (or a zero delay): release the thread now
                    if (slot_ticks[s] <= 1)
                    begin
                        slot_taken[s] = 1'b0;
                        slot_ticks[s] = '0;
                        if (sleepers != 0)
                            sleepers = sleepers - 1'b1;
                        step_results.push_back(make_result(sct_pkg::KIND_WOKEN,
                                                           slot_thread[s],
                                                           sct_pkg::SLOT_W'(s), sleepers,
                                                           1'b0));
                    end
                    else
                        slot_ticks[s] = slot_ticks[s] - 1'b1;
                end
            end
            if (step_results.size() == 0)
                step_results.push_back(make_result(sct_pkg::KIND_IDLE, '0, '0, sleepers,
                                                   1'b1));
            else
                step_results[step_results.size() - 1].last = 1'b1;
        end
    endfunction

    function automatic void row(logic cmd, logic [sct_pkg::ID_W-1:0] id,
                                logic [sct_pkg::DELAY_W-1:0] delay,
                                bit typed, sct_pkg::kind_t kind,
                                logic [sct_pkg::SLOT_W-1:0] slot,
                                logic [sct_pkg::WAIT_W-1:0] waiting);
        stim_row_t r;
        r.cmd   = cmd;
        r.id    = id;
        r.delay = delay;
        r.typed = typed;
        r.want  = make_result(kind, id, slot, waiting, 1'b1);
        directed_rows.push_back(r);
    endfunction

    // Mostly back-to-back or short gaps, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(10, 40);
    endfunction

    // Keep most delays short so threads wake within the run; a rare full-range
    // delay parks a thread for good and exercises the top delay bits.
    function automatic logic [sct_pkg::DELAY_W-1:0] pick_delay();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return sct_pkg::DELAY_W'($urandom_range(0, 4));
        else if (r < 99)
            return sct_pkg::DELAY_W'($urandom_range(5, 40));
        else
            return sct_pkg::DELAY_W'($urandom_range(0, 65535));
    endfunction

    // Offer one request from a falling edge, hold it until the transfer, then
    // log what it should cause. Return on the next falling edge.
    task automatic transfer_request(logic cmd, logic [sct_pkg::ID_W-1:0] id,
                                    logic [sct_pkg::DELAY_W-1:0] delay, bit typed,
                                    wake_result_t want, bit quiet);
        int gap;
        gap = quiet ? 0 : pick_gap();
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_ch.valid     <= 1'b1;
        req_ch.cmd       <= cmd;
        req_ch.thread_id <= id;
        req_ch.delay     <= delay;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        // transfer taken: the table copy moves on, expectations are queued
        advance_table(cmd, id, delay);
        if (typed)
            due_results.push_back(want);
        else
            foreach (step_results[i])
                due_results.push_back(step_results[i]);
        @(negedge clk);
    endtask

    // Clock: 10 ns period.
    initial
    begin
        clk = 1'b0;
        forever
            #5 clk = ~clk;
    end

    // Reset once, released on a falling edge.
    initial
    begin
        rst_n = 1'b0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
    end

    // Hard stop in case the block hangs.
    initial
    begin
        #(TIMEOUT_NS);
        $display("end of test: mismatches");
        $finish;
    end

    // Result side: random back-pressure, one long hold-off that lets the block
    // fill up and stall its input, and a field-by-field check of every transfer.
    initial
    begin
        int           gap;
        int           taken;
        bit           held_off;
        bit           quiet;
        wake_result_t want;
        taken    = 0;
        held_off = 1'b0;
        rsp_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(negedge clk);
        forever
        begin
            // quiet stretch: every fourth run of 48 results is taken at full rate
            quiet = ((taken / 48) % 4) == 1;
            gap   = quiet ? 0 : pick_gap();
            if (!held_off && taken >= 40)
            begin
                held_off = 1'b1;
                gap      = gap + HOLD_CYCLES;
            end
            if (gap > 0)
            begin
                rsp_ch.ready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            rsp_ch.ready <= 1'b1;
            @(posedge clk);
            while (!rsp_ch.valid)
                @(posedge clk);
            taken++;
            if (due_results.size() == 0)
            begin
                $error("unexpected result: kind %0d thread %0d slot %0d",
                       rsp_ch.kind, rsp_ch.woken_thread, rsp_ch.slot_index);
                faults++;
            end
            else
            begin
                want = due_results.pop_front();
                if (rsp_ch.kind !== want.kind)
                begin
                    $error("kind: expected %0d, got %0d", want.kind, rsp_ch.kind);
                    faults++;
                end
                if (rsp_ch.woken_thread !== want.thread)
                begin
                    $error("woken_thread: expected %0d, got %0d",
                           want.thread, rsp_ch.woken_thread);
                    faults++;
                end
                if (rsp_ch.slot_index !== want.slot)
                begin
                    $error("slot_index: expected %0d, got %0d", want.slot, rsp_ch.slot_index);
                    faults++;
                end
                if (rsp_ch.waiting_count !== want.waiting)
                begin
                    $error("waiting_count: expected %0d, got %0d",
                           want.waiting, rsp_ch.waiting_count);
                    faults++;
                end
                if (rsp_ch.last !== want.last)
                begin
                    $error("last: expected %0d, got %0d", want.last, rsp_ch.last);
                    faults++;
                end
            end
            @(negedge clk);
        end
    end

    // Request side: directed table first, then random traffic, then drain.
    initial
    begin
        logic                        cmd;
        logic [sct_pkg::ID_W-1:0]    id;
        logic [sct_pkg::DELAY_W-1:0] delay;
        int                          sleep_pct;

        faults = 0;
        for (int s = 0; s < NUM_SLOTS; s++)
        begin
            slot_taken[s]  = 1'b0;
            slot_thread[s] = '0;
            slot_ticks[s]  = '0;
        end
        sleepers = '0;

        req_ch.valid     <= 1'b0;
        req_ch.cmd       <= CMD_TICK;
        req_ch.thread_id <= '0;
        req_ch.delay     <= '0;

        //  cmd        id     delay     typed kind                slot wait
        row(CMD_TICK,  8'h00, 16'h0000, 1, sct_pkg::KIND_IDLE,  0,  0);  // tick on empty table
        row(CMD_SLEEP, 8'hFF, 16'h0000, 1, sct_pkg::KIND_SLEEP, 0,  1);  // zero delay
        row(CMD_SLEEP, 8'h00, 16'hFFFF, 1, sct_pkg::KIND_SLEEP, 1,  2);  // longest delay
        row(CMD_SLEEP, 8'hA5, 16'h0001, 1, sct_pkg::KIND_SLEEP, 2,  3);
        row(CMD_SLEEP, 8'h5A, 16'h0002, 1, sct_pkg::KIND_SLEEP, 3,  4);
        row(CMD_TICK,  8'h00, 16'h0000, 0, sct_pkg::KIND_IDLE,  0,  0);  // two wakes
        row(CMD_TICK,  8'hFF, 16'hFFFF, 0, sct_pkg::KIND_IDLE,  0,  0);  // single wake
        // refill the freed slots and fill the table to the brim
        row(CMD_SLEEP, 8'h01, 16'd3,    0, sct_pkg::KIND_SLEEP, 0,  0);
        row(CMD_SLEEP, 8'h02, 16'd3,    0, sct_pkg::KIND_SLEEP, 0,  0);
        row(CMD_SLEEP, 8'h04, 16'd4,    0, sct_pkg::KIND_SLEEP, 0,  0);
        row(CMD_SLEEP, 8'h08, 16'd5,    0, sct_pkg::KIND_SLEEP, 0,  0);
        row(CMD_SLEEP, 8'h10, 16'd6,    0, sct_pkg::KIND_SLEEP, 0,  0);
        row(CMD_SLEEP, 8'h20, 16'd7,    0, sct_pkg::KIND_SLEEP, 0,  0);
        row(CMD_SLEEP, 8'h40, 16'd8,    0, sct_pkg::KIND_SLEEP, 0,  0);
        row(CMD_SLEEP, 8'h80, 16'd9,    0, sct_pkg::KIND_SLEEP, 0,  0);
        row(CMD_SLEEP, 8'h7E, 16'd10,   0, sct_pkg::KIND_SLEEP, 0,  0);
        row(CMD_SLEEP, 8'h3C, 16'd7,    1, sct_pkg::KIND_FULL,  0, 10);  // table full
        row(CMD_SLEEP, 8'hFF, 16'hFFFF, 1, sct_pkg::KIND_FULL,  0, 10);  // full, extremes
        row(CMD_TICK,  8'h00, 16'h0000, 0, sct_pkg::KIND_IDLE,  0,  0);  // full, no wake
        row(CMD_TICK,  8'h00, 16'h0000, 0, sct_pkg::KIND_IDLE,  0,  0);
        row(CMD_TICK,  8'h00, 16'h0000, 0, sct_pkg::KIND_IDLE,  0,  0);  // first pair wakes
        row(CMD_TICK,  8'h00, 16'h0000, 0, sct_pkg::KIND_IDLE,  0,  0);
        row(CMD_TICK,  8'h00, 16'h0000, 0, sct_pkg::KIND_IDLE,  0,  0);

        wait (rst_n === 1'b1);
        @(negedge clk);

        foreach (directed_rows[i])
            transfer_request(directed_rows[i].cmd, directed_rows[i].id,
                             directed_rows[i].delay, directed_rows[i].typed,
                             directed_rows[i].want, 1'b0);

        // Random part: the share of sleep requests swings between phases so the
        // table alternates between draining, steady occupancy and running full.
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            case ((n / 50) % 3)
                0:       sleep_pct = 35;
                1:       sleep_pct = 50;
                default: sleep_pct = 75;
            endcase
            cmd   = ($urandom_range(0, 99) < sleep_pct) ? CMD_SLEEP : CMD_TICK;
            id    = sct_pkg::ID_W'($urandom_range(0, 255));
            delay = pick_delay();
            transfer_request(cmd, id, delay, 1'b0, '0, ((n / 48) % 4) == 2);
        end
        req_ch.valid <= 1'b0;

        // Drain: wait for every awaited result, then give stray ones time to show.
        while (due_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (faults == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

[files.f]
hdl/sct_pkg.sv
hdl/sct_in_if.sv
hdl/sct_out_if.sv
hdl/sct_ram.sv
hdl/sct_ctrl.sv
hdl/sct_dpath.sv
hdl/sleep_countdown_table.sv
tb/tb.sv
